FILE: hw/rtl/pcgr_pkg.sv
// ----------------------------------------------------------------------------
// pcgr_pkg
// shared widths, command codes, queue entry and control structs of the
// per-channel gain ramp unit
// ----------------------------------------------------------------------------
package pcgr_pkg;

   // item field widths
   localparam int CH_W     = 4;
   localparam int CHANNELS = 2 ** CH_W;
   localparam int POS_W    = 10;
   localparam int FRAMES_W = 11;
   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 16;

   // ramp arithmetic widths
   localparam int STEP_W     = 34;
   localparam int QUO_W      = 32;
   localparam int DIV_CNT_W  = $clog2(QUO_W + 1);
   localparam int RAMP_W     = 44;
   localparam int RAMP_FRAC  = 16;
   localparam int GSUM_W     = RAMP_W - RAMP_FRAC + 1;
   localparam int SCALE_W    = SAMPLE_W + GAIN_W + 1;
   localparam int SCALE_FRAC = 12;
   localparam int SHIFTED_W  = SCALE_W - SCALE_FRAC;

   // block length limit
   localparam logic [FRAMES_W-1:0] MAX_FRAMES = 11'd1024;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAMES    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_GAIN = 1'b1;
   localparam logic [FRAMES_W-1:0]    FRAMES_RESET    = 11'd256;
   localparam logic [GAIN_W-1:0]      INIT_GAIN_RESET = 16'd4096;

   // command codes on the request channel
   localparam logic [1:0] CMD_PROCESS   = 2'd0;
   localparam logic [1:0] CMD_SET_GAIN  = 2'd1;
   localparam logic [1:0] CMD_READ_GAIN = 2'd2;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // classified operation
   typedef enum logic [2:0] {
      OP_PROCESS,
      OP_SET_GAIN,
      OP_READ_GAIN,
      OP_BAD_POS,
      OP_IGNORE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CH_W-1:0]     channel;
      logic [POS_W-1:0]    pos;
      logic [SAMPLE_W-1:0] sample;
      logic [GAIN_W-1:0]   gain_value;
      logic                block_start;
      logic                block_end;
   } entry_type;

   typedef struct packed {
      logic [FRAMES_W-1:0] frames;
      logic [GAIN_W-1:0]   initial_gain;
   } cfg_type;

   typedef struct packed {
      logic                start;
      logic [QUO_W-1:0]    dividend;
      logic [FRAMES_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_MUL_STEP,
      BK_GAIN,
      BK_MUL_SAMPLE,
      BK_SAT,
      BK_OUT
   } back_state_type;

endpackage

FILE: hw/rtl/pcgr_if.sv
// ----------------------------------------------------------------------------
// pcgr_if
// request and response channel interfaces with valid/ready handshake
// ----------------------------------------------------------------------------
interface pcgr_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic [pcgr_pkg::CH_W-1:0]     channel;
   logic [pcgr_pkg::POS_W-1:0]    sample_pos;
   logic [pcgr_pkg::SAMPLE_W-1:0] sample_in;
   logic [pcgr_pkg::GAIN_W-1:0]   gain_value;

   modport source (
      output valid, cmd, channel, sample_pos, sample_in, gain_value,
      input  ready
   );
   modport sink (
      input  valid, cmd, channel, sample_pos, sample_in, gain_value,
      output ready
   );
endinterface

interface pcgr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pcgr_pkg::SAMPLE_W-1:0] sample_out;
   logic [pcgr_pkg::GAIN_W-1:0]   gain_read;
   logic                          bad_position;

   modport source (
      output valid, sample_out, gain_read, bad_position,
      input  ready
   );
   modport sink (
      input  valid, sample_out, gain_read, bad_position,
      output ready
   );
endinterface

FILE: hw/rtl/pcgr_front.sv
// ----------------------------------------------------------------------------
// pcgr_front
// configuration registers, request acceptance and item classification
// ----------------------------------------------------------------------------
module pcgr_front (
   input  logic                                clock,
   input  logic                                reset,
   pcgr_req_if.sink                            req_bus,
   input  logic                                csr_wr_en,
   input  logic [pcgr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pcgr_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  logic                                q_full,
   output logic                                q_push,
   output pcgr_pkg::entry_type                 q_push_data,
   output pcgr_pkg::cfg_type                   cfg
);
   import pcgr_pkg::*;

   logic [FRAMES_W-1:0] frames_ff, frames_in;
   logic [GAIN_W-1:0]   init_gain_ff, init_gain_in;
   logic [FRAMES_W-1:0] frames_sat;
   logic [FRAMES_W-1:0] pos_ext;
   logic                bad_pos;

   // register writes
   always_comb begin
      frames_in    = frames_ff;
      init_gain_in = init_gain_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAMES:    frames_in    = csr_wr_data[FRAMES_W-1:0];
            CSR_INIT_GAIN: init_gain_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff    <= FRAMES_RESET;
         init_gain_ff <= INIT_GAIN_RESET;
      end else begin
         frames_ff    <= frames_in;
         init_gain_ff <= init_gain_in;
      end
   end

   // block length clipped to the supported maximum
   assign frames_sat = (frames_ff > MAX_FRAMES) ? MAX_FRAMES : frames_ff;
   assign pos_ext    = {1'b0, req_bus.sample_pos};
   assign bad_pos    = (frames_sat == '0) || (pos_ext >= frames_sat);

   assign cfg.frames       = frames_sat;
   assign cfg.initial_gain = init_gain_ff;

   // transfer into the queue whenever it has room
   assign req_bus.ready = !q_full;
   assign q_push        = req_bus.valid && !q_full;

   // classification
   always_comb begin
      q_push_data.channel     = req_bus.channel;
      q_push_data.pos         = req_bus.sample_pos;
      q_push_data.sample      = req_bus.sample_in;
      q_push_data.gain_value  = req_bus.gain_value;
      q_push_data.block_start = (req_bus.sample_pos == '0);
      q_push_data.block_end   = (pos_ext == frames_sat - FRAMES_W'(1));
      unique case (req_bus.cmd)
         CMD_PROCESS:   q_push_data.op = bad_pos ? OP_BAD_POS : OP_PROCESS;
         CMD_SET_GAIN:  q_push_data.op = OP_SET_GAIN;
         CMD_READ_GAIN: q_push_data.op = OP_READ_GAIN;
         default:       q_push_data.op = OP_IGNORE;
      endcase
   end

endmodule

FILE: hw/rtl/pcgr_queue.sv
// ----------------------------------------------------------------------------
// pcgr_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module pcgr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pcgr_pkg::entry_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output pcgr_pkg::entry_type head
);
   import pcgr_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/pcgr_div.sv
// ----------------------------------------------------------------------------
// pcgr_div
// restoring divider, one quotient bit per cycle, for the ramp step
// ----------------------------------------------------------------------------
module pcgr_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pcgr_pkg::div_req_type req,
   output pcgr_pkg::div_rsp_type rsp
);
   import pcgr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [FRAMES_W-1:0]  rem_ff, rem_in;
   logic [FRAMES_W-1:0]  divisor_ff, divisor_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [FRAMES_W:0]    trial;
   logic [FRAMES_W:0]    trial_sub;
   logic                 fits;

   // one shift-and-subtract step
   assign trial     = {rem_ff, quo_ff[QUO_W-1]};
   assign fits      = (trial >= {1'b0, divisor_ff});
   assign trial_sub = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CNT_W'(QUO_W);
         rem_in     = '0;
         divisor_in = req.divisor;
         quo_in     = req.dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? trial_sub[FRAMES_W-1:0] : trial[FRAMES_W-1:0];
         quo_in   = {quo_ff[QUO_W-2:0], fits};
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

FILE: hw/rtl/pcgr_back.sv
// ----------------------------------------------------------------------------
// pcgr_back
// per-channel gain state, ramp evaluation, sample scaling and result register
// ----------------------------------------------------------------------------
module pcgr_back (
   input  logic                clock,
   input  logic                reset,
   input  pcgr_pkg::cfg_type   cfg,
   input  logic                q_empty,
   input  pcgr_pkg::entry_type q_head,
   output logic                q_pop,
   pcgr_rsp_if.source          rsp_bus
);
   import pcgr_pkg::*;

   back_state_type state_ff, state_in;
   entry_type      entry_ff, entry_in;
   logic           neg_ff, neg_in;

   // datapath registers
   logic signed [RAMP_W-1:0]  ramp_prod_ff, ramp_prod_in;
   logic [GAIN_W-1:0]         gain_ff, gain_in;
   logic signed [SCALE_W-1:0] scale_prod_ff, scale_prod_in;
   logic [SAMPLE_W-1:0]       res_sample_ff, res_sample_in;
   logic [GAIN_W-1:0]         res_gain_ff, res_gain_in;
   logic                      res_bad_ff, res_bad_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff;
   logic [GAIN_W-1:0]   rsp_gain_ff;
   logic                rsp_bad_ff;

   // per-channel state
   logic [GAIN_W-1:0]        target_ff     [CHANNELS];
   logic [CHANNELS-1:0]      written_ff;
   logic [GAIN_W-1:0]        prev_ff       [CHANNELS];
   logic [CHANNELS-1:0]      prev_valid_ff;
   logic [GAIN_W-1:0]        bstart_ff     [CHANNELS];
   logic signed [STEP_W-1:0] bstep_ff      [CHANNELS];
   logic [GAIN_W-1:0]        btarget_ff    [CHANNELS];

   // write strobes
   logic target_we;
   logic block_we;
   logic step_we;
   logic end_we;
   logic out_load;
   logic out_free;

   // divider
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [CH_W-1:0]          ch_h;
   logic [CH_W-1:0]          ch;
   logic [GAIN_W-1:0]        eff_target_h;
   logic [GAIN_W-1:0]        eff_prev_h;
   logic signed [GAIN_W:0]   diff;
   logic [GAIN_W:0]          diff_neg;
   logic [GAIN_W-1:0]        diff_mag;
   logic [STEP_W-1:0]        quo_ext;
   logic signed [STEP_W-1:0] step_val;
   logic signed [RAMP_W:0]   ramp_full;
   logic signed [GSUM_W-1:0] ramp_floor;
   logic signed [GSUM_W-1:0] gain_sum;
   logic signed [SHIFTED_W-1:0] scaled;

   pcgr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // effective gains of the channel at the queue head
   assign ch_h         = q_head.channel;
   assign ch           = entry_ff.channel;
   assign eff_target_h = written_ff[ch_h] ? target_ff[ch_h] : cfg.initial_gain;
   assign eff_prev_h   = prev_valid_ff[ch_h] ? prev_ff[ch_h] : cfg.initial_gain;
   assign diff         = $signed({1'b0, eff_target_h}) - $signed({1'b0, eff_prev_h});
   assign diff_neg     = -diff;
   assign diff_mag     = diff[GAIN_W] ? diff_neg[GAIN_W-1:0] : diff[GAIN_W-1:0];

   // signed step from the quotient magnitude
   assign quo_ext  = {{(STEP_W-QUO_W){1'b0}}, div_rsp.quotient};
   assign step_val = neg_ff ? -$signed(quo_ext) : $signed(quo_ext);

   // ramp offset with floor rounding, then start gain added
   assign ramp_full  = bstep_ff[ch] * $signed({1'b0, entry_ff.pos});
   assign ramp_floor = $signed({ramp_prod_ff[RAMP_W-1], ramp_prod_ff[RAMP_W-1:RAMP_FRAC]});
   assign gain_sum   = $signed({{(GSUM_W-GAIN_W){1'b0}}, bstart_ff[ch]}) + ramp_floor;

   // product scaled down with floor rounding
   assign scaled = scale_prod_ff[SCALE_W-1:SCALE_FRAC];

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // sequencer
   always_comb begin
      state_in         = state_ff;
      entry_in         = entry_ff;
      neg_in           = neg_ff;
      ramp_prod_in     = ramp_prod_ff;
      gain_in          = gain_ff;
      scale_prod_in    = scale_prod_ff;
      res_sample_in    = res_sample_ff;
      res_gain_in      = res_gain_ff;
      res_bad_in       = res_bad_ff;
      q_pop            = 1'b0;
      target_we        = 1'b0;
      block_we         = 1'b0;
      step_we          = 1'b0;
      end_we           = 1'b0;
      out_load         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = {diff_mag, {(QUO_W-GAIN_W){1'b0}}};
      div_req.divisor  = cfg.frames;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop         = 1'b1;
               entry_in      = q_head;
               res_sample_in = '0;
               res_gain_in   = '0;
               res_bad_in    = 1'b0;
               state_in      = BK_OUT;
               case (q_head.op)
                  OP_PROCESS: begin
                     if (q_head.block_start) begin
                        block_we      = 1'b1;
                        div_req.start = 1'b1;
                        neg_in        = diff[GAIN_W];
                        state_in      = BK_DIV;
                     end else begin
                        state_in = BK_MUL_STEP;
                     end
                  end
                  OP_SET_GAIN:  target_we   = 1'b1;
                  OP_READ_GAIN: res_gain_in = eff_target_h;
                  OP_BAD_POS:   res_bad_in  = 1'b1;
                  default: ;
               endcase
            end
         end
         BK_DIV: begin
            if (div_rsp.done) begin
               step_we  = 1'b1;
               state_in = BK_MUL_STEP;
            end
         end
         BK_MUL_STEP: begin
            ramp_prod_in = ramp_full[RAMP_W-1:0];
            state_in     = BK_GAIN;
         end
         BK_GAIN: begin
            if (gain_sum[GSUM_W-1]) begin
               gain_in = '0;
            end else if (|gain_sum[GSUM_W-2:GAIN_W]) begin
               gain_in = '1;
            end else begin
               gain_in = gain_sum[GAIN_W-1:0];
            end
            state_in = BK_MUL_SAMPLE;
         end
         BK_MUL_SAMPLE: begin
            scale_prod_in = $signed(entry_ff.sample) * $signed({1'b0, gain_ff});
            state_in      = BK_SAT;
         end
         BK_SAT: begin
            if (!(&scaled[SHIFTED_W-1:SAMPLE_W-1]) && (|scaled[SHIFTED_W-1:SAMPLE_W-1])) begin
               res_sample_in = scaled[SHIFTED_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                                   : {1'b0, {(SAMPLE_W-1){1'b1}}};
            end else begin
               res_sample_in = scaled[SAMPLE_W-1:0];
            end
            end_we   = entry_ff.block_end;
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // response handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff      <= entry_in;
      neg_ff        <= neg_in;
      ramp_prod_ff  <= ramp_prod_in;
      gain_ff       <= gain_in;
      scale_prod_ff <= scale_prod_in;
      res_sample_ff <= res_sample_in;
      res_gain_ff   <= res_gain_in;
      res_bad_ff    <= res_bad_in;
      if (out_load) begin
         rsp_sample_ff <= res_sample_ff;
         rsp_gain_ff   <= res_gain_ff;
         rsp_bad_ff    <= res_bad_ff;
      end
   end

   // channel state with a defined reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         prev_valid_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            bstart_ff[i]  <= '0;
            bstep_ff[i]   <= '0;
            btarget_ff[i] <= '0;
         end
      end else begin
         if (target_we) begin
            written_ff[ch_h] <= 1'b1;
         end
         if (block_we) begin
            bstart_ff[ch_h]  <= eff_prev_h;
            btarget_ff[ch_h] <= eff_target_h;
         end
         if (step_we) begin
            bstep_ff[ch] <= step_val;
         end
         if (end_we) begin
            prev_valid_ff[ch] <= 1'b1;
         end
      end
   end

   // channel state qualified by valid bits
   always_ff @(posedge clock) begin
      if (target_we) begin
         target_ff[ch_h] <= q_head.gain_value;
      end
      if (end_we) begin
         prev_ff[ch] <= btarget_ff[ch];
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.sample_out   = rsp_sample_ff;
   assign rsp_bus.gain_read    = rsp_gain_ff;
   assign rsp_bus.bad_position = rsp_bad_ff;

   // divider runs for as long as the step is awaited
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV) |-> (div_rsp.busy || div_rsp.done))
      else $error("step wait without divider activity");

   // items leave the queue only between items
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == BK_IDLE) && !q_empty)
      else $error("queue pop outside idle or from empty queue");

   // a finished result always reaches the response register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_OUT) && out_free |=> rsp_valid_ff && (state_ff == BK_IDLE))
      else $error("result not presented");

endmodule

FILE: hw/rtl/per_channel_gain_ramp_unit.sv
// ----------------------------------------------------------------------------
// per_channel_gain_ramp_unit
// sixteen-channel audio gain with linear per-block ramps between gain settings
// ----------------------------------------------------------------------------
// Requests transfer into a two-entry queue and are served one at a time by the
// back end, which holds one result in its response register while the next
// request may already be queued. Set, read, ignored and bad-position requests
// pass through the back end as the pop into result staging, then the response
// register. A sample within a block passes the pop, the step-times-position
// multiply, the gain add and clamp, the sample-times-gain multiply,
// saturation into staging and the response register. A sample at block
// position 0 first waits for the restoring divider that forms the ramp step,
// one quotient bit per cycle. Configuration takes effect on the next request;
// the user is to write it only while idle, which the block does not enforce.
module per_channel_gain_ramp_unit (
   input  logic                             clock,
   input  logic                             reset,
   pcgr_req_if.sink                         req_bus,
   pcgr_rsp_if.source                       rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [pcgr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pcgr_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import pcgr_pkg::*;

   logic      q_full;
   logic      q_empty;
   logic      q_push;
   logic      q_pop;
   entry_type q_push_data;
   entry_type q_head;
   cfg_type   cfg;

   // request side
   pcgr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data),
      .cfg         (cfg)
   );

   // decoupling queue
   pcgr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   // execution side
   pcgr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

FILE: tb/pcgr_gain_checker.sv
// ----------------------------------------------------------------------------
// pcgr_gain_checker
// watches the request, response and register ports of the gain ramp unit,
// computes the scaled sample, read-back gain and position flag of every
// request transfer and compares each response transfer with the oldest one
// ----------------------------------------------------------------------------
module pcgr_gain_checker (
   input  logic                             clock,
   input  logic                             reset,
   pcgr_req_if                              req_mon,
   pcgr_rsp_if                              rsp_mon,
   input  logic                             csr_wr_en,
   input  logic [pcgr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pcgr_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output int                               mismatch_count,
   output int                               results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   import pcgr_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_out;
      logic [GAIN_W-1:0]   gain_read;
      logic                bad_position;
   } gain_result_type;

   // register copies
   logic [FRAMES_W-1:0] frames_cfg;
   logic [GAIN_W-1:0]   init_gain_cfg;

   // per-channel gain state
   logic [GAIN_W-1:0] target_gain [CHANNELS];
   bit                gain_written [CHANNELS];
   logic [GAIN_W-1:0] prev_gain [CHANNELS];
   bit                prev_valid [CHANNELS];
   logic [GAIN_W-1:0] start_gain [CHANNELS];
   longint            ramp_step [CHANNELS];
   logic [GAIN_W-1:0] ramp_target [CHANNELS];

   gain_result_type results_due [$];

   // applies one command to the channel state and returns its response
   function automatic gain_result_type apply_command(
      input logic [1:0]          cmd,
      input logic [CH_W-1:0]     ch,
      input logic [POS_W-1:0]    pos,
      input logic [SAMPLE_W-1:0] sample,
      input logic [GAIN_W-1:0]   gval
   );
      gain_result_type r;
      int unsigned     frames;
      longint          diff;
      longint          gain;
      longint          smp;
      longint          scaled;

      r = '0;
      frames = 32'((frames_cfg > MAX_FRAMES) ? MAX_FRAMES : frames_cfg);
      case (cmd)
         CMD_SET_GAIN: begin
            target_gain[ch] = gval;
            gain_written[ch] = 1'b1;
         end
         CMD_READ_GAIN: begin
            r.gain_read = gain_written[ch] ? target_gain[ch] : init_gain_cfg;
         end
         CMD_PROCESS: begin
            if (frames == 0 || pos >= frames) begin
               r.bad_position = 1'b1;
            end else begin
               // block start latches the ramp end points and its step
               if (pos == 0) begin
                  start_gain[ch]  = prev_valid[ch] ? prev_gain[ch] : init_gain_cfg;
                  ramp_target[ch] = gain_written[ch] ? target_gain[ch] : init_gain_cfg;
                  diff = longint'(ramp_target[ch]) - longint'(start_gain[ch]);
                  ramp_step[ch] = (diff * 65536) / longint'(frames);
               end
               gain = longint'(start_gain[ch]) + ((ramp_step[ch] * longint'(pos)) >>> 16);
               if (gain < 0) gain = 0;
               if (gain > 65535) gain = 65535;

               // scale, floor the fraction away, saturate
               smp = longint'($signed(sample));
               scaled = (smp * gain) >>> SCALE_FRAC;
               if (scaled > 64'sd8388607) scaled = 64'sd8388607;
               if (scaled < -64'sd8388608) scaled = -64'sd8388608;
               r.sample_out = scaled[SAMPLE_W-1:0];

               // block end hands the target over as the next start gain
               if (pos == frames - 1) begin
                  prev_gain[ch]  = ramp_target[ch];
                  prev_valid[ch] = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      gain_result_type want;
      gain_result_type due;
      if (reset) begin
         frames_cfg = FRAMES_RESET;
         init_gain_cfg = INIT_GAIN_RESET;
         foreach (gain_written[i]) begin
            gain_written[i] = 1'b0;
            prev_valid[i]   = 1'b0;
            prev_gain[i]    = '0;
            start_gain[i]   = '0;
            ramp_step[i]    = 0;
            ramp_target[i]  = '0;
         end
         results_due.delete();
         mismatch_count = 0;
         results_owed <= 0;
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FRAMES:    frames_cfg = csr_wr_data[FRAMES_W-1:0];
               CSR_INIT_GAIN: init_gain_cfg = csr_wr_data[GAIN_W-1:0];
               default: ;
            endcase
         end

         // response transfer against the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (results_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: response with none outstanding: %s %h %h %b",
                           $time, "sample_out/gain_read/bad_position",
                           rsp_mon.sample_out, rsp_mon.gain_read, rsp_mon.bad_position);
            end else begin
               want = results_due.pop_front();
               if (rsp_mon.sample_out !== want.sample_out ||
                   rsp_mon.gain_read !== want.gain_read ||
                   rsp_mon.bad_position !== want.bad_position) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: mismatch: sample_out exp %h got %h, %s %h got %h, %s %b got %b",
                              $time, want.sample_out, rsp_mon.sample_out,
                              "gain_read exp", want.gain_read, rsp_mon.gain_read,
                              "bad_position exp", want.bad_position,
                              rsp_mon.bad_position);
               end
            end
         end

         // request transfer
         if (req_mon.valid && req_mon.ready) begin
            due = apply_command(req_mon.cmd, req_mon.channel, req_mon.sample_pos,
                                req_mon.sample_in, req_mon.gain_value);
            results_due.insert(results_due.size(), due);
         end

         results_owed <= results_due.size();
      end
   end

endmodule

FILE: tb/tb_per_channel_gain_ramp_unit.sv
// ----------------------------------------------------------------------------
// tb_per_channel_gain_ramp_unit
// drives commands into the gain ramp unit through a directed opening and
// randomized phases under several block lengths and initial gains, with
// random gaps on both channels; the checker beside the unit scores results
// ----------------------------------------------------------------------------
module tb_per_channel_gain_ramp_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import pcgr_pkg::*;

   localparam int         CYCLE_LIMIT  = 1_000_000;
   localparam int         PHASE_COUNT  = 10;
   localparam int         PHASE_ITEMS  = 190;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   int                     mismatch_count;
   int                     results_owed;
   int                     cycle_count = 0;
   int                     sent_items = 0;
   bit                     no_gaps = 1'b0;
   logic [FRAMES_W-1:0]    frames_now;

   pcgr_req_if req_bus ();
   pcgr_rsp_if rsp_bus ();

   per_channel_gain_ramp_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   pcgr_gain_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[per_channel_gain_ramp_unit] ERROR");
         $finish;
      end
   end

   // response side: random stalls before each transfer
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (rsp_bus.valid !== 1'b1) @(posedge clock);
      end
   end

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'hFFFFFF;
         3: return 24'h000000;
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'd4096;
         default: return GAIN_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // one request transfer after a random gap
   task automatic send_item(input logic [1:0] cmd, input int ch, input int pos,
                            input logic [SAMPLE_W-1:0] smp, input logic [GAIN_W-1:0] gval);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.channel    <= ch[CH_W-1:0];
      req_bus.sample_pos <= pos[POS_W-1:0];
      req_bus.sample_in  <= smp;
      req_bus.gain_value <= gval;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      if (cmd != CMD_UNUSED) sent_items++;
   endtask

   // hold off requests until every response has come, then let the unit go quiet
   task automatic settle(input int quiet);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (quiet) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // one block on a channel: position 0, ascending positions, last position;
   // short blocks are walked in full, long ones sparsely; zero length sends random positions
   task automatic run_block(input int ch);
      int fe;
      int p;
      fe = int'((frames_now > MAX_FRAMES) ? MAX_FRAMES : frames_now);
      if (fe == 0) begin
         repeat ($urandom_range(1, 3))
            send_item(CMD_PROCESS, ch, $urandom_range(0, 1023), pick_sample(),
                      GAIN_W'($urandom()));
      end else begin
         p = 0;
         while (p < fe) begin
            send_item(CMD_PROCESS, ch, p, pick_sample(), GAIN_W'($urandom()));
            // other traffic inside the block now and then
            if ($urandom_range(0, 5) == 0)
               send_item($urandom_range(0, 1) ? CMD_SET_GAIN : CMD_READ_GAIN,
                         $urandom_range(0, CHANNELS - 1), $urandom_range(0, 1023),
                         pick_sample(), pick_gain());
            if (p == fe - 1)
               p = fe;
            else if (fe <= 12)
               p = p + 1;
            else begin
               p = p + $urandom_range(1, fe / 3);
               if (p > fe - 1) p = fe - 1;
            end
         end
      end
   endtask

   // mostly well-formed blocks with random content, some noise
   task automatic run_phase(input int items);
      int stop;
      int ch;
      stop = sent_items + items;
      while (sent_items < stop) begin
         ch = $urandom_range(0, CHANNELS - 1);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               if ($urandom_range(0, 1))
                  send_item(CMD_SET_GAIN, ch, $urandom_range(0, 1023), pick_sample(), pick_gain());
               run_block(ch);
            end
            6: send_item(CMD_SET_GAIN, ch, $urandom_range(0, 1023), pick_sample(), pick_gain());
            7: send_item(CMD_READ_GAIN, ch, $urandom_range(0, 1023), pick_sample(),
                         GAIN_W'($urandom()));
            8: send_item(CMD_PROCESS, ch, $urandom_range(0, 1023), pick_sample(),
                         GAIN_W'($urandom()));
            default:
               send_item(CMD_UNUSED, ch, $urandom_range(0, 1023), pick_sample(),
                         GAIN_W'($urandom()));
         endcase
      end
   endtask

   // stimulus and verdict
   initial begin
      logic [FRAMES_W-1:0] frames_list [PHASE_COUNT];
      logic [GAIN_W-1:0]   gain_list [PHASE_COUNT];

      frames_list = '{11'd256, 11'd1, 11'd1024, 11'd0, 11'd2047,
                      11'd3, 11'd1025, 11'd17, 11'd64, 11'd5};
      gain_list   = '{16'd4096, 16'd0, 16'hFFFF, 16'd4096, 16'd12345,
                      16'd0, 16'd4096, 16'hFFFF, 16'd0, 16'd0};

      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_PROCESS;
      req_bus.channel    = '0;
      req_bus.sample_pos = '0;
      req_bus.sample_in  = '0;
      req_bus.gain_value = '0;
      frames_now         = FRAMES_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset block length and initial gain
      send_item(CMD_PROCESS, 0, 5, 24'h123456, 16'h0000);     // no block start seen yet
      send_item(CMD_READ_GAIN, 3, 0, 24'h000000, 16'h0000);   // never written channel
      send_item(CMD_SET_GAIN, 3, 0, 24'h000000, 16'hFFFF);
      send_item(CMD_READ_GAIN, 3, 0, 24'h000000, 16'h0000);
      send_item(CMD_UNUSED, 15, 1023, 24'hFFFFFF, 16'hFFFF);  // unused command
      send_item(CMD_PROCESS, 3, 0, 24'h7FFFFF, 16'h0000);     // ramp up from initial gain
      send_item(CMD_PROCESS, 3, 128, 24'h400000, 16'h0000);
      send_item(CMD_PROCESS, 3, 255, 24'h800000, 16'h0000);   // block end
      send_item(CMD_PROCESS, 3, 256, 24'h7FFFFF, 16'h0000);   // position past block
      send_item(CMD_PROCESS, 3, 1023, 24'h000000, 16'h0000);
      send_item(CMD_PROCESS, 3, 0, 24'h7FFFFF, 16'h0000);     // constant gain, positive clip
      send_item(CMD_PROCESS, 3, 1, 24'h800000, 16'h0000);     // negative clip
      send_item(CMD_PROCESS, 3, 2, 24'hFFFFFF, 16'h0000);     // floor of a small negative
      send_item(CMD_SET_GAIN, 12, 0, 24'h000000, 16'h0000);
      send_item(CMD_PROCESS, 12, 0, 24'hFFFFFF, 16'h0000);    // ramp down to mute
      send_item(CMD_PROCESS, 12, 200, 24'h000001, 16'h0000);
      send_item(CMD_PROCESS, 12, 255, 24'h7FFFFF, 16'h0000);
      send_item(CMD_PROCESS, 12, 0, 24'h7FFFFF, 16'h0000);    // muted block
      send_item(CMD_SET_GAIN, 15, 0, 24'h000000, 16'h1234);
      send_item(CMD_READ_GAIN, 15, 0, 24'h000000, 16'h0000);
      send_item(CMD_PROCESS, 15, 0, 24'h555555, 16'hAAAA);

      // random phases, registers changed only while idle
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         settle(50);
         if (ph > 0) begin
            write_reg(CSR_FRAMES, CSR_DATA_W'(frames_list[ph]));
            write_reg(CSR_INIT_GAIN, gain_list[ph]);
            frames_now = frames_list[ph];
         end
         no_gaps = (ph == 2) || ($urandom_range(0, 3) == 0);
         run_phase(PHASE_ITEMS);
      end

      settle(50);
      if (mismatch_count == 0 && results_owed == 0)
         $display("[per_channel_gain_ramp_unit] OK");
      else
         $display("[per_channel_gain_ramp_unit] ERROR");
      $finish;
   end

endmodule
